// ===== design/bds_pkg.sv =====
// ============================================================================
// bds_pkg: shared types and constants for the blur / 2x downsample block
// Sizes, register indexes, the item handed from front to back, and the
// reciprocal constants used for the rounded divide by 9, 12 or 16.
// ============================================================================
package bds_pkg;

    // Line store and pixel geometry
    localparam int LINE_DEPTH  = 2048;
    localparam int COL_BITS    = $clog2(LINE_DEPTH);
    localparam int MAX_HEIGHT  = 4096;
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int PIX_BITS    = 8;
    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 13;

    // Configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 13;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0),
        CFG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1)
    } cfg_index_t;

    // Column partial sum: up to 1+2+1 pixels
    localparam int TAP_BITS = PIX_BITS + 2;
    // Full kernel sum plus rounding offset: up to 16 pixels
    localparam int SUM_BITS = PIX_BITS + 4;

    // Queue between front and back
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    // Reciprocals scaled by 2**RECIP_SHIFT, rounded up; exact for sums < 4096
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_BITS  = 13;
    localparam logic [RECIP_BITS-1:0] RECIP_9  = RECIP_BITS'(7282);
    localparam logic [RECIP_BITS-1:0] RECIP_12 = RECIP_BITS'(5462);
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    typedef enum logic [1:0] {
        DIV_16,
        DIV_12,
        DIV_9
    } div_sel_t;

    // One output's worth of work handed from front to back
    typedef struct packed {
        logic [TAP_BITS-1:0] left;
        logic [TAP_BITS-1:0] mid;
        logic [TAP_BITS-1:0] right;
        logic                top_row;
        logic                left_col;
        logic                line_last;
        logic                frame_last;
    } bds_item_t;

endpackage

// ===== design/bds_front.sv =====
// ============================================================================
// bds_front: pixel intake, counters, line store and window
// Accepts pixels, tracks column and row, reads and rewrites the two line
// rows, shifts the 3x2 window and pushes column sums for odd/odd positions.
// ============================================================================
module bds_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bds_pkg::WIDTH_BITS-1:0]    image_width,
    input  logic [bds_pkg::HEIGHT_BITS-1:0]   image_height,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  logic [bds_pkg::PIX_BITS-1:0]      pix_data,
    input  logic [bds_pkg::FIFO_CNT_BITS-1:0] fifo_count,
    output logic                              push,
    output bds_pkg::bds_item_t                push_item
);
    import bds_pkg::*;

    localparam int LINE_WORD = 2 * PIX_BITS;

    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [WIDTH_BITS-1:0]  w_even;
    logic [HEIGHT_BITS-1:0] h_even;
    logic [COL_BITS-1:0]    col_last;
    logic [ROW_BITS-1:0]    row_last;
    logic                   line_end, frame_end, accept;

    // stage 1 (line store data returned)
    logic                   f1_valid_reg;
    logic [COL_BITS-1:0]    f1_col_reg;
    logic [PIX_BITS-1:0]    f1_pix_reg;
    logic                   f1_emit_reg, f1_top_reg, f1_left_reg;
    logic                   f1_line_reg, f1_frame_reg;
    logic [LINE_WORD-1:0]   rd_data_reg;
    logic [PIX_BITS-1:0]    old_pix, new_pix;

    logic [LINE_WORD-1:0]   line_mem [LINE_DEPTH];
    logic [PIX_BITS-1:0]    win_reg [6];

    // Effective frame size: even, saturated to the supported range
    always_comb begin
        w_even = {image_width[WIDTH_BITS-1:1], 1'b0};
        h_even = {image_height[HEIGHT_BITS-1:1], 1'b0};
        if (w_even < WIDTH_BITS'(2)) begin
            col_last = COL_BITS'(1);
        end else if (int'(w_even) > LINE_DEPTH) begin
            col_last = COL_BITS'((LINE_DEPTH & ~1) - 1);
        end else begin
            col_last = COL_BITS'(w_even - WIDTH_BITS'(1));
        end
        if (h_even < HEIGHT_BITS'(2)) begin
            row_last = ROW_BITS'(1);
        end else if (int'(h_even) > MAX_HEIGHT) begin
            row_last = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            row_last = ROW_BITS'(h_even - HEIGHT_BITS'(1));
        end
    end

    assign line_end  = (col_reg >= col_last);
    assign frame_end = (row_reg >= row_last);

    // Take a pixel only when the queue has room for everything in flight
    assign pix_ready = ({1'b0, fifo_count} + FIFO_CNT_BITS'(f1_valid_reg)) <
                       (FIFO_CNT_BITS + 1)'(FIFO_DEPTH);
    assign accept    = pix_valid && pix_ready;

    // Advance column and row counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (line_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            f1_valid_reg <= accept;
        end
    end

    // Capture pixel and position flags for stage 1
    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_col_reg   <= col_reg;
            f1_pix_reg   <= pix_data;
            f1_emit_reg  <= row_reg[0] && col_reg[0];
            f1_top_reg   <= (row_reg == ROW_BITS'(1));
            f1_left_reg  <= (col_reg == COL_BITS'(1));
            f1_line_reg  <= line_end;
            f1_frame_reg <= line_end && frame_end;
        end
    end

    // Line store: read older/newer pair on intake, rewrite it in the next cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (f1_valid_reg) begin
            line_mem[f1_col_reg] <= {new_pix, f1_pix_reg};
        end
    end

    assign old_pix = rd_data_reg[LINE_WORD-1:PIX_BITS];
    assign new_pix = rd_data_reg[PIX_BITS-1:0];

    // Shift the window by one column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (f1_valid_reg) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= old_pix;
            win_reg[4] <= new_pix;
            win_reg[5] <= f1_pix_reg;
        end
    end

    // Column sums with 0-2-1 or 1-2-1 row weights
    always_comb begin
        push_item.left  = (f1_top_reg ? TAP_BITS'(0) : TAP_BITS'(win_reg[0]))
                        + {1'b0, win_reg[1], 1'b0} + TAP_BITS'(win_reg[2]);
        push_item.mid   = (f1_top_reg ? TAP_BITS'(0) : TAP_BITS'(win_reg[3]))
                        + {1'b0, win_reg[4], 1'b0} + TAP_BITS'(win_reg[5]);
        push_item.right = (f1_top_reg ? TAP_BITS'(0) : TAP_BITS'(old_pix))
                        + {1'b0, new_pix, 1'b0} + TAP_BITS'(f1_pix_reg);
        push_item.top_row    = f1_top_reg;
        push_item.left_col   = f1_left_reg;
        push_item.line_last  = f1_line_reg;
        push_item.frame_last = f1_frame_reg;
    end

    assign push = f1_valid_reg && f1_emit_reg;

endmodule

// ===== design/bds_fifo.sv =====
// ============================================================================
// bds_fifo: short queue between front and back
// Holds pending output work so intake and output can stall independently.
// ============================================================================
module bds_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  bds_pkg::bds_item_t                push_item,
    input  logic                              pop,
    output logic                              pop_valid,
    output bds_pkg::bds_item_t                pop_item,
    output logic [bds_pkg::FIFO_CNT_BITS-1:0] count
);
    import bds_pkg::*;

    bds_item_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic                     do_pop;

    assign pop_valid = (count_reg != '0);
    assign do_pop    = pop && pop_valid;
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            end
            count_reg <= count_reg + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(do_pop);
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/bds_back.sv =====
// ============================================================================
// bds_back: kernel sum, rounded divide and output register
// Adds column sums with their weights, picks the divisor, divides by
// reciprocal multiply (or shift for 16) and holds the result until the sink takes it.
// ============================================================================
module bds_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_valid,
    input  bds_pkg::bds_item_t           item,
    output logic                         item_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bds_pkg::PIX_BITS-1:0] out_pixel,
    output logic                         out_line_last,
    output logic                         out_frame_last
);
    import bds_pkg::*;

    logic                 b1_valid_reg;
    logic [SUM_BITS-1:0]  b1_sum_reg;
    div_sel_t             b1_div_reg;
    logic                 b1_line_reg, b1_frame_reg;
    logic                 out_valid_reg;
    logic [PIX_BITS-1:0]  out_pixel_reg;
    logic                 out_line_reg, out_frame_reg;
    logic                 out_en, b1_en;
    logic [SUM_BITS-1:0]  sum_raw, sum_round;
    div_sel_t             div_sel;
    logic [PROD_BITS-1:0] prod;
    logic [PIX_BITS-1:0]  quot;

    assign out_en   = !out_valid_reg || out_ready;
    assign b1_en    = !b1_valid_reg || out_en;
    assign item_pop = item_valid && b1_en;

    // Weighted sum and rounding offset
    always_comb begin
        sum_raw = (item.left_col ? SUM_BITS'(0) : SUM_BITS'(item.left))
                + SUM_BITS'({item.mid, 1'b0}) + SUM_BITS'(item.right);
        priority if (item.top_row && item.left_col) begin
            div_sel   = DIV_9;
            sum_round = sum_raw + SUM_BITS'(4);
        end else if (item.top_row || item.left_col) begin
            div_sel   = DIV_12;
            sum_round = sum_raw + SUM_BITS'(6);
        end else begin
            div_sel   = DIV_16;
            sum_round = sum_raw + SUM_BITS'(8);
        end
    end

    // Divide by reciprocal multiply, or by shift for 16
    always_comb begin
        prod = '0;
        unique case (b1_div_reg)
            DIV_9: begin
                prod = PROD_BITS'(b1_sum_reg) * PROD_BITS'(RECIP_9);
                quot = prod[RECIP_SHIFT +: PIX_BITS];
            end
            DIV_12: begin
                prod = PROD_BITS'(b1_sum_reg) * PROD_BITS'(RECIP_12);
                quot = prod[RECIP_SHIFT +: PIX_BITS];
            end
            DIV_16: begin
                quot = b1_sum_reg[4 +: PIX_BITS];
            end
            default: begin
                quot = '0;
            end
        endcase
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (b1_en) begin
                b1_valid_reg <= item_valid;
            end
            if (out_en) begin
                out_valid_reg <= b1_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (item_pop) begin
            b1_sum_reg   <= sum_round;
            b1_div_reg   <= div_sel;
            b1_line_reg  <= item.line_last;
            b1_frame_reg <= item.frame_last;
        end
        if (out_en && b1_valid_reg) begin
            out_pixel_reg <= quot;
            out_line_reg  <= b1_line_reg;
            out_frame_reg <= b1_frame_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_pixel      = out_pixel_reg;
    assign out_line_last  = out_line_reg;
    assign out_frame_last = out_frame_reg;

endmodule

// ===== design/blur_downsample_2x_3x3.sv =====
// ============================================================================
// blur_downsample_2x_3x3: 3x3 binomial blur with 2x decimation
// Top level: configuration registers, front, queue and back.
// ============================================================================
// Accepts one 8-bit pixel per clock in raster order while the queue has
// room, and sends one half-size pixel for every pixel at an odd row and odd
// column. From the accepting edge the column sums are formed from the line
// store read and pushed into the queue, pass through the queue to the kernel
// sum register and then through the divide into the result on m_tvalid. The
// line store is a single 2048 x 16 memory that is read when a pixel is
// taken and written back the next clock. It needs no clearing after reset.
// Output (k,j) is centered on input (2k,2j) and is rounded to nearest; on the
// first output row and column the kernel is cut at the top or left edge.
// m_tlast marks the last pixel of each output row and m_tuser the last of
// the frame.
// Write image_width and image_height only while no pixels are in flight.
module blur_downsample_2x_3x3 (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // input pixels
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] pixel_in
    // output pixels
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] pixel_out
    output logic                                m_tlast,   // line_last
    output logic                                m_tuser    // [0] frame_last
);
    import bds_pkg::*;

    logic [WIDTH_BITS-1:0]    image_width_reg;
    logic [HEIGHT_BITS-1:0]   image_height_reg;
    logic                     push, pop, pop_valid;
    bds_item_t                push_item, pop_item;
    logic [FIFO_CNT_BITS-1:0] fifo_count;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default: begin
                    image_width_reg <= image_width_reg;
                end
            endcase
        end
    end

    bds_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .pix_valid    (s_tvalid),
        .pix_ready    (s_tready),
        .pix_data     (s_tdata),
        .fifo_count   (fifo_count),
        .push         (push),
        .push_item    (push_item)
    );

    bds_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .count     (fifo_count)
    );

    bds_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (pop_valid),
        .item           (pop_item),
        .item_pop       (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_pixel      (m_tdata),
        .out_line_last  (m_tlast),
        .out_frame_last (m_tuser)
    );

endmodule

// ===== design/bds_checker.sv =====
// ============================================================================
// bds_checker: port-level checks for the blur / downsample block
// Watches the result channel over time; bound to the top level.
// ============================================================================
module bds_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [7:0]                          m_tdata,
    input logic                                m_tlast,
    input logic                                m_tuser
);
    // Stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its fields
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // End of frame is always also end of an output row
    a_frame_on_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without line end");

    // Reset empties the output stage
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind blur_downsample_2x_3x3 bds_checker u_bds_checker (.*);
